>>> rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants, codes and types of the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int CFG_DATA_W         = 12;
    localparam int CFG_ADDR_W         = 2;
    localparam int SCREEN_W           = 14;
    localparam int COLOUR_W           = 24;
    localparam int CHAN_W             = 8;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CFG_DATA_W-1:0] CENTRE_X_RESET = 12'd512;
    localparam logic [CFG_DATA_W-1:0] CENTRE_Y_RESET = 12'd384;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTRE_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTRE_Y = 2'd1;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic                  en;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // queued item: colour, degenerate, dirs, spans, endpoints, start point, cmd
    function automatic int item_width(input int coord_bits);
        return 6 * coord_bits + COLOUR_W + 4;
    endfunction

endpackage

>>> rtl/lpg_front.sv
// ----------------------------------------------------------------------------
// lpg_front
// Accepts input items, works out spans, directions and the degenerate flag
// of a start item, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module lpg_front
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic signed [COORD_BITS-1:0]       s_start_x,
    input  logic signed [COORD_BITS-1:0]       s_start_y,
    input  logic signed [COORD_BITS-1:0]       s_end_x,
    input  logic signed [COORD_BITS-1:0]       s_end_y,
    input  logic        [COLOUR_W-1:0]         s_colour,
    input  queue_status_t                      q_status,
    output logic                               push,
    output logic [item_width(COORD_BITS)-1:0]  push_data
);

    logic signed [COORD_BITS:0]   diff_x;
    logic signed [COORD_BITS:0]   diff_y;
    logic        [COORD_BITS:0]   abs_x;
    logic        [COORD_BITS:0]   abs_y;
    logic        [COORD_BITS-1:0] span_x;
    logic        [COORD_BITS-1:0] span_y;
    logic                         dir_x;
    logic                         dir_y;
    logic                         degenerate;

    assign diff_x = (COORD_BITS+1)'(s_end_x) - (COORD_BITS+1)'(s_start_x);
    assign diff_y = (COORD_BITS+1)'(s_end_y) - (COORD_BITS+1)'(s_start_y);

    assign abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
    assign abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
    assign span_x = abs_x[COORD_BITS-1:0];
    assign span_y = abs_y[COORD_BITS-1:0];

    // negative unless start lies strictly below end on that axis
    assign dir_x = diff_x[COORD_BITS] || (diff_x == '0);
    assign dir_y = diff_y[COORD_BITS] || (diff_y == '0);

    assign degenerate = (diff_x == '0) && (diff_y == '0);

    assign s_ready   = !q_status.full;
    assign push      = s_valid && s_ready;
    assign push_data = {s_colour, degenerate, dir_y, dir_x, span_y, span_x,
                        s_end_y, s_end_x, s_start_y, s_start_x, s_cmd};

endmodule

>>> rtl/lpg_queue.sv
// ----------------------------------------------------------------------------
// lpg_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module lpg_queue
    import lpg_pkg::*;
#(
    parameter int DATA_W = item_width(COORD_BITS_DEFAULT)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output queue_status_t     q_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data       = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

>>> rtl/lpg_back.sv
// ----------------------------------------------------------------------------
// lpg_back
// Line state and stepper: takes one queued item a cycle while not stalled,
// advances the Bresenham point and loads the result into the output register.
// ----------------------------------------------------------------------------
module lpg_back
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cfg_write_t                        cfg,
    input  logic [item_width(COORD_BITS)-1:0] pop_data,
    input  queue_status_t                     q_status,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_pixel_valid,
    output logic signed [SCREEN_W-1:0]        m_screen_x,
    output logic signed [SCREEN_W-1:0]        m_screen_y,
    output logic [CHAN_W-1:0]                 m_red,
    output logic [CHAN_W-1:0]                 m_green,
    output logic [CHAN_W-1:0]                 m_blue,
    output logic                              m_last
);

    localparam int ERR_W   = COORD_BITS + 2;
    localparam int TWICE_W = COORD_BITS + 3;
    localparam int SUM_W   = ((COORD_BITS > CFG_DATA_W) ? COORD_BITS : CFG_DATA_W) + 2;

    // queue head fields
    logic                         h_cmd;
    logic signed [COORD_BITS-1:0] h_start_x, h_start_y, h_end_x, h_end_y;
    logic        [COORD_BITS-1:0] h_span_x, h_span_y;
    logic                         h_dir_x, h_dir_y, h_degenerate;
    logic        [COLOUR_W-1:0]   h_colour;

    assign {h_colour, h_degenerate, h_dir_y, h_dir_x, h_span_y, h_span_x,
            h_end_y, h_end_x, h_start_y, h_start_x, h_cmd} = pop_data;

    // configuration
    logic [CFG_DATA_W-1:0] centre_x_reg, centre_y_reg;

    // line state
    logic signed [COORD_BITS-1:0] point_x_reg, point_y_reg;
    logic signed [COORD_BITS-1:0] target_x_reg, target_y_reg;
    logic signed [ERR_W-1:0]      err_reg;
    logic        [COORD_BITS-1:0] span_x_reg, span_y_reg;
    logic                         dir_x_reg, dir_y_reg;
    logic        [COLOUR_W-1:0]   colour_reg;
    logic                         active_reg, active_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic                       pix_valid_reg;
    logic signed [SCREEN_W-1:0] screen_x_reg, screen_y_reg;
    logic [CHAN_W-1:0]          red_reg, green_reg, blue_reg;
    logic                       last_reg;

    // step arithmetic
    logic signed [TWICE_W-1:0]    twice, span_x_w, span_y_w, neg_span_y;
    logic                         move_x, move_y;
    logic signed [ERR_W-1:0]      err_step;
    logic signed [COORD_BITS-1:0] step_x, step_y;
    logic                         fin;

    assign twice      = {err_reg, 1'b0};
    assign span_x_w   = $signed({3'b000, span_x_reg});
    assign span_y_w   = $signed({3'b000, span_y_reg});
    assign neg_span_y = -span_y_w;
    assign move_x     = twice > neg_span_y;
    assign move_y     = twice < span_x_w;

    always_comb begin
        err_step = err_reg;
        step_x   = point_x_reg;
        step_y   = point_y_reg;
        if (move_x) begin
            err_step = err_step - $signed({2'b00, span_y_reg});
            step_x   = dir_x_reg ? point_x_reg - COORD_BITS'(1)
                                 : point_x_reg + COORD_BITS'(1);
        end
        if (move_y) begin
            err_step = err_step + $signed({2'b00, span_x_reg});
            step_y   = dir_y_reg ? point_y_reg - COORD_BITS'(1)
                                 : point_y_reg + COORD_BITS'(1);
        end
    end

    assign fin = (step_x == target_x_reg) && (step_y == target_y_reg);

    // result selection
    logic                         is_start;
    logic                         emit_pixel;
    logic signed [COORD_BITS-1:0] emit_x, emit_y;
    logic [COLOUR_W-1:0]          emit_colour;
    logic                         emit_last;
    logic [SUM_W-1:0]             sum_x, sum_y;

    assign is_start = (h_cmd == CMD_START);

    always_comb begin
        if (is_start) begin
            emit_pixel  = 1'b1;
            emit_x      = h_end_x;
            emit_y      = h_end_y;
            emit_colour = h_colour;
            emit_last   = h_degenerate;
            active_next = !h_degenerate;
        end else if (active_reg) begin
            emit_pixel  = 1'b1;
            emit_x      = point_x_reg;
            emit_y      = point_y_reg;
            emit_colour = colour_reg;
            emit_last   = fin;
            active_next = !fin;
        end else begin
            emit_pixel  = 1'b0;
            emit_x      = '0;
            emit_y      = '0;
            emit_colour = '0;
            emit_last   = 1'b0;
            active_next = 1'b0;
        end
    end

    assign sum_x = SUM_W'(emit_x) + SUM_W'(centre_x_reg);
    assign sum_y = SUM_W'(centre_y_reg) - SUM_W'(emit_y);

    assign pop = !q_status.empty && (!out_valid_reg || m_ready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg  <= CENTRE_X_RESET;
            centre_y_reg  <= CENTRE_Y_RESET;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg.en) begin
                unique case (cfg.addr)
                    CFG_CENTRE_X: centre_x_reg <= cfg.data;
                    CFG_CENTRE_Y: centre_y_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (pop) begin
                active_reg <= active_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (is_start) begin
                point_x_reg  <= h_start_x;
                point_y_reg  <= h_start_y;
                target_x_reg <= h_end_x;
                target_y_reg <= h_end_y;
                span_x_reg   <= h_span_x;
                span_y_reg   <= h_span_y;
                err_reg      <= $signed({2'b00, h_span_x}) - $signed({2'b00, h_span_y});
                dir_x_reg    <= h_dir_x;
                dir_y_reg    <= h_dir_y;
                colour_reg   <= h_colour;
            end else if (active_reg) begin
                point_x_reg <= step_x;
                point_y_reg <= step_y;
                err_reg     <= err_step;
            end
            pix_valid_reg <= emit_pixel;
            screen_x_reg  <= emit_pixel ? sum_x[SCREEN_W-1:0] : '0;
            screen_y_reg  <= emit_pixel ? sum_y[SCREEN_W-1:0] : '0;
            red_reg       <= emit_colour[2*CHAN_W +: CHAN_W];
            green_reg     <= emit_colour[CHAN_W +: CHAN_W];
            blue_reg      <= emit_colour[0 +: CHAN_W];
            last_reg      <= emit_last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_valid = pix_valid_reg;
    assign m_screen_x    = screen_x_reg;
    assign m_screen_y    = screen_y_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;
    assign m_last        = last_reg;

endmodule

>>> rtl/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// line_pixel_generator
// Bresenham line rasteriser producing one result per start or step command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): a start command (s_cmd = 0) latches both
//   endpoints and the colour and returns the end pixel; each step command
//   (s_cmd = 1) returns the current point and advances it. A step with no
//   line in progress returns a result with m_pixel_valid low and zero fields.
//   Output channel (m_valid/m_ready): exactly one result per command, in
//   order; m_last marks the final pixel of a line.
//   Configuration: cfg_wr_en/cfg_addr/cfg_wdata write centre_x (index 0) and
//   centre_y (index 1); write only while the block is idle.
// Timing:
//   Each item is registered in the queue, then in the output register.
//   Throughput is one item per cycle unless the receiver stalls, set by the
//   combinational back-end add/compare step on the registered line state.
//   When the receiver stalls, the result holds in the output register and the
//   two-entry queue absorbs up to two further items before s_ready drops.
// Reset: aresetn (synchronous, active low) empties the queue and output
//   register, drops any line and restores centre_x = 512, centre_y = 384.
// ----------------------------------------------------------------------------
module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic signed [COORD_BITS-1:0] s_start_x,
    input  logic signed [COORD_BITS-1:0] s_start_y,
    input  logic signed [COORD_BITS-1:0] s_end_x,
    input  logic signed [COORD_BITS-1:0] s_end_y,
    input  logic [COLOUR_W-1:0]          s_colour,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_pixel_valid,
    output logic signed [SCREEN_W-1:0]   m_screen_x,
    output logic signed [SCREEN_W-1:0]   m_screen_y,
    output logic [CHAN_W-1:0]            m_red,
    output logic [CHAN_W-1:0]            m_green,
    output logic [CHAN_W-1:0]            m_blue,
    output logic                         m_last
);

    localparam int ITEM_W = item_width(COORD_BITS);

    cfg_write_t        cfg;
    queue_status_t     q_status;
    logic              push;
    logic [ITEM_W-1:0] push_data;
    logic              pop;
    logic [ITEM_W-1:0] pop_data;

    assign cfg.en   = cfg_wr_en;
    assign cfg.addr = cfg_addr;
    assign cfg.data = cfg_wdata;

    lpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_start_x  (s_start_x),
        .s_start_y  (s_start_y),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .s_colour   (s_colour),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    lpg_queue #(
        .DATA_W     (ITEM_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .pop_data   (pop_data),
        .q_status   (q_status)
    );

    lpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .pop_data      (pop_data),
        .q_status      (q_status),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_valid (m_pixel_valid),
        .m_screen_x    (m_screen_x),
        .m_screen_y    (m_screen_y),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_last        (m_last)
    );

endmodule

>>> rtl/lpg_checker.sv
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks on the line pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
module lpg_checker
    import lpg_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_pixel_valid,
    input logic signed [SCREEN_W-1:0] m_screen_x,
    input logic signed [SCREEN_W-1:0] m_screen_y,
    input logic [CHAN_W-1:0]          m_red,
    input logic [CHAN_W-1:0]          m_green,
    input logic [CHAN_W-1:0]          m_blue,
    input logic                       m_last
);

    // stalled result holds until its transfer
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_valid) &&
            $stable(m_screen_x) && $stable(m_screen_y) && $stable(m_red) &&
            $stable(m_green) && $stable(m_blue) && $stable(m_last))
        else $error("stalled result changed");

    // a step with no line gives an all-zero result
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pixel_valid |-> m_screen_x == '0 && m_screen_y == '0 &&
            m_red == '0 && m_green == '0 && m_blue == '0 && !m_last)
        else $error("no-pixel result carries data");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind line_pixel_generator lpg_checker u_checker (.*);
